/* sv/pts_pkg.sv */
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the packed 2-bit symbol vector
// Sizes, operation and status codes, sequencer states and slot masks.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int WORD_COUNT = 64;
    localparam int SYMS_PER_WORD = 32;
    localparam int WORD_W = 64;
    localparam int SLOT_W = 5;
    localparam int SYM_W = 2;
    localparam int ACTION_W = 3;
    localparam int POS_W = 12;
    localparam int STATUS_W = 2;
    localparam int LEN_W = 12;
    localparam int ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int CAPACITY = WORD_COUNT * SYMS_PER_WORD;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_GET    = 3'd0,
        ACT_SET    = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_WALK,
        S_FINISH
    } state_t;

    // Mask of the bits below slot s, s in 0..32.
    function automatic logic [WORD_W-1:0] below_mask(input logic [SLOT_W:0] s);
        logic [WORD_W-1:0] m;
        if (s[SLOT_W])
        begin
            m = '1;
        end
        else
        begin
            m = (WORD_W'(1) << {s[SLOT_W-1:0], 1'b0}) - WORD_W'(1);
        end
        return m;
    endfunction

endpackage

/* sv/pts_req_if.sv */
// ----------------------------------------------------------------------------
// pts_req_if: request channel of the packed 2-bit symbol vector
// Valid/ready handshake carrying one operation.
// ----------------------------------------------------------------------------
interface pts_req_if;
    logic                           valid;
    logic                           ready;
    logic [pts_pkg::ACTION_W-1:0]   action;
    logic [pts_pkg::POS_W-1:0]      position;
    logic [pts_pkg::SYM_W-1:0]      symbol;

    modport source (output valid, action, position, symbol, input ready);
    modport sink (input valid, action, position, symbol, output ready);
endinterface

/* sv/pts_rsp_if.sv */
// ----------------------------------------------------------------------------
// pts_rsp_if: result channel of the packed 2-bit symbol vector
// Valid/ready handshake carrying one operation result.
// ----------------------------------------------------------------------------
interface pts_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [pts_pkg::SYM_W-1:0]      read_symbol;
    logic [pts_pkg::STATUS_W-1:0]   status;
    logic [pts_pkg::LEN_W-1:0]      length;
    logic [pts_pkg::WORD_W-1:0]     digest;

    modport source (output valid, read_symbol, status, length, digest, input ready);
    modport sink (input valid, read_symbol, status, length, digest, output ready);
endinterface

/* sv/pts_ram.sv */
// ----------------------------------------------------------------------------
// pts_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

/* sv/packed_two_bit_symbol_vector_core.sv */
// ----------------------------------------------------------------------------
// packed_two_bit_symbol_vector_core: packed 2-bit symbol sequence store
// Get, set, insert, remove and clear on a sequence of 2-bit symbols held
// 32 to a 64-bit word in one RAM, with a running XOR digest of all words.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-------------------------------------------
//  req     | in  | valid / ready | action, position, symbol
//  rsp     | out | valid / ready | read_symbol, status, length, digest
//
//  Sequencing: one request at a time. Errors, clear and unused codes go from
//  accept through EVAL to FINISH; get and set pass through WALK for word w
//  alone; insert walks from the addressed word up to the top and remove from
//  the top down to it, one word per cycle through the RAM read port.
//  Reset: clears sequencer, length, digest and per-word valid bits at once;
//  a word whose valid bit is low reads as zero, so no clearing pass is run.
//  Stalls: a result waits in the output register; the next request is taken
//  meanwhile and its own result holds in FINISH until the register frees.
// ----------------------------------------------------------------------------
module packed_two_bit_symbol_vector_core (
    input  logic clk,
    input  logic rst_n,
    pts_req_if.sink   req,
    pts_rsp_if.source rsp
);
    import pts_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(WORD_COUNT - 1);

    // Sequencer and request registers
    state_t                 state_reg, state_next;
    action_t                action_reg, action_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [SYM_W-1:0]       sym_reg, sym_next;
    status_t                status_reg, status_next;
    logic [SYM_W-1:0]       rd_sym_reg, rd_sym_next;
    logic [ADDR_W-1:0]      idx_reg, idx_next;
    logic [SYM_W-1:0]       carry_reg, carry_next;

    // Architectural state outside the RAM
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [WORD_W-1:0]      xor_reg, xor_next;
    logic [WORD_COUNT-1:0]  vld_reg, vld_next;
    logic                   rd_vld_reg, rd_vld_next;

    // Output register
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [SYM_W-1:0]       rsp_sym_reg, rsp_sym_next;
    logic [STATUS_W-1:0]    rsp_status_reg, rsp_status_next;
    logic [LEN_W-1:0]       rsp_len_reg, rsp_len_next;
    logic [WORD_W-1:0]      rsp_digest_reg, rsp_digest_next;

    // RAM port signals
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [WORD_W-1:0]      ram_rdata;

    // Control decode
    logic [ADDR_W-1:0]      w_idx;
    logic [SLOT_W-1:0]      slot;
    logic [SLOT_W:0]        shamt;
    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       cnt_ext;
    logic                   is_full;
    status_t                eval_status;
    logic                   eval_walk;
    logic                   at_w;
    logic                   walk_last;
    logic                   out_free;

    // Word datapath
    logic [WORD_W-1:0]      word_q;
    logic [WORD_W-1:0]      slot_mask;
    logic [WORD_W-1:0]      low_mask;
    logic [WORD_W-1:0]      keep_mask;
    logic [WORD_W-1:0]      new_word;

    pts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORD_COUNT)
    ) u_words (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Control decode: range checks and walk bounds
    // ------------------------------------------------------------------
    always_comb
    begin
        w_idx    = ADDR_W'(pos_reg >> SLOT_W);
        slot     = pos_reg[SLOT_W-1:0];
        shamt    = {slot, 1'b0};
        pos_ext  = CMP_W'(pos_reg);
        cnt_ext  = CMP_W'(cnt_reg);
        is_full  = (cnt_reg == CNT_W'(CAPACITY));
        at_w     = (idx_reg == w_idx);
        out_free = !rsp_valid_reg || rsp.ready;

        eval_status = ST_OK;
        eval_walk   = 1'b0;
        unique case (action_reg)
            ACT_GET, ACT_SET, ACT_REMOVE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    eval_status = ST_RANGE;
                end
                else
                begin
                    eval_walk = 1'b1;
                end
            end
            ACT_INSERT:
            begin
                // index check ahead of the full check
                if (pos_ext > cnt_ext)
                begin
                    eval_status = ST_RANGE;
                end
                else if (is_full)
                begin
                    eval_status = ST_FULL;
                end
                else
                begin
                    eval_walk = 1'b1;
                end
            end
            default:
            begin
                eval_walk = 1'b0;
            end
        endcase

        // Insert walks up to the top word, everything else ends at word w
        if (action_reg == ACT_INSERT)
        begin
            walk_last = (idx_reg == LAST_IDX);
        end
        else
        begin
            walk_last = at_w;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = eval_walk ? S_WALK : S_FINISH;
            end
            S_WALK:
            begin
                if (walk_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Word datapath: read data and the rewritten word
    // ------------------------------------------------------------------
    always_comb
    begin
        word_q    = rd_vld_reg ? ram_rdata : '0;
        slot_mask = WORD_W'(3) << shamt;
        low_mask  = below_mask({1'b0, slot});
        keep_mask = below_mask({1'b0, slot} + (SLOT_W+1)'(1));
        new_word  = word_q;
        unique case (action_reg)
            ACT_SET:
            begin
                new_word = (word_q & ~slot_mask) | (WORD_W'(sym_reg) << shamt);
            end
            ACT_INSERT:
            begin
                if (at_w)
                begin
                    // open a gap at the slot and drop the new symbol in
                    new_word = (word_q & low_mask) | ((word_q & ~low_mask) << 2)
                             | (WORD_W'(sym_reg) << shamt);
                end
                else
                begin
                    new_word = (word_q << 2) | WORD_W'(carry_reg);
                end
            end
            ACT_REMOVE:
            begin
                if (at_w)
                begin
                    // close the gap and pull in the bottom of the word above
                    new_word = (word_q & low_mask) | ((word_q & ~keep_mask) >> 2)
                             | {carry_reg, {(WORD_W-SYM_W){1'b0}}};
                end
                else
                begin
                    new_word = (word_q >> 2) | {carry_reg, {(WORD_W-SYM_W){1'b0}}};
                end
            end
            default:
            begin
                new_word = word_q;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer: RAM accesses and register updates
    // ------------------------------------------------------------------
    always_comb
    begin
        action_next     = action_reg;
        pos_next        = pos_reg;
        sym_next        = sym_reg;
        status_next     = status_reg;
        rd_sym_next     = rd_sym_reg;
        idx_next        = idx_reg;
        carry_next      = carry_reg;
        cnt_next        = cnt_reg;
        xor_next        = xor_reg;
        vld_next        = vld_reg;
        rd_vld_next     = rd_vld_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_sym_next    = rsp_sym_reg;
        rsp_status_next = rsp_status_reg;
        rsp_len_next    = rsp_len_reg;
        rsp_digest_next = rsp_digest_reg;

        req.ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = new_word;
        ram_re    = 1'b0;
        ram_raddr = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    action_next = action_t'(req.action);
                    pos_next    = req.position;
                    sym_next    = req.symbol;
                end
            end
            S_EVAL:
            begin
                status_next = eval_status;
                rd_sym_next = '0;
                carry_next  = '0;
                if (eval_walk)
                begin
                    // remove walks down from the top; the others start at w
                    ram_re    = 1'b1;
                    ram_raddr = (action_reg == ACT_REMOVE) ? LAST_IDX : w_idx;
                    idx_next  = ram_raddr;
                    rd_vld_next = vld_reg[ram_raddr];
                end
                if (action_reg == ACT_CLEAR)
                begin
                    vld_next = '0;
                    cnt_next = '0;
                    xor_next = '0;
                end
            end
            S_WALK:
            begin
                if (action_reg == ACT_GET)
                begin
                    rd_sym_next = SYM_W'(word_q >> shamt);
                end
                else
                begin
                    ram_we            = 1'b1;
                    xor_next          = xor_reg ^ word_q ^ new_word;
                    vld_next[idx_reg] = 1'b1;
                end
                carry_next = (action_reg == ACT_REMOVE) ? word_q[SYM_W-1:0]
                                                        : word_q[WORD_W-1 -: SYM_W];
                if (walk_last)
                begin
                    if (action_reg == ACT_INSERT)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    else if (action_reg == ACT_REMOVE)
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    // advance to the next word while this one is written
                    ram_re      = 1'b1;
                    ram_raddr   = (action_reg == ACT_INSERT) ? idx_reg + ADDR_W'(1)
                                                             : idx_reg - ADDR_W'(1);
                    idx_next    = ram_raddr;
                    rd_vld_next = vld_reg[ram_raddr];
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_sym_next    = rd_sym_reg;
                    rsp_status_next = status_reg;
                    rsp_len_next    = LEN_W'(cnt_reg);
                    rsp_digest_next = WORD_W'(LEN_W'(cnt_reg)) ^ xor_reg;
                end
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            xor_reg       <= '0;
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            xor_reg       <= xor_next;
            vld_reg       <= vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        pos_reg        <= pos_next;
        sym_reg        <= sym_next;
        status_reg     <= status_next;
        rd_sym_reg     <= rd_sym_next;
        idx_reg        <= idx_next;
        carry_reg      <= carry_next;
        rd_vld_reg     <= rd_vld_next;
        rsp_sym_reg    <= rsp_sym_next;
        rsp_status_reg <= rsp_status_next;
        rsp_len_reg    <= rsp_len_next;
        rsp_digest_reg <= rsp_digest_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_symbol = rsp_sym_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.length      = rsp_len_reg;
    assign rsp.digest      = rsp_digest_reg;

`ifndef SYNTHESIS
    // Length never goes beyond the capacity of the RAM
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("symbol count above capacity");

    // The RAM is written only while walking words
    a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_WALK))
        else $error("RAM write outside the word walk");

    // A full status is reported only with a full store
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && status_reg == ST_FULL) |-> is_full)
        else $error("full status with room left");

    // A successful insert grows the length by one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && action_reg == ACT_INSERT && walk_last)
        |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("insert did not grow the length");
`endif

endmodule
